### src/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types, command codes and helpers of the budget accounting block.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int TIME_BITS   = 64;  // width of time fields on the ports
  localparam int BUDGET_BITS = 40;
  localparam int THRESH_BITS = 20;
  localparam int CNT_BITS    = 32;
  localparam int CMD_BITS    = 3;
  localparam int CFG_BITS    = 40;  // widest register
  localparam int LANES       = 3;   // job one, job two, period

  localparam int LANE_ONE = 0;
  localparam int LANE_TWO = 1;
  localparam int LANE_PER = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(5000);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_FIRST_JOB  = 3'd0,
    CMD_BOUNDARY1  = 3'd1,
    CMD_BOUNDARY2  = 3'd2,
    CMD_SCHED_IN   = 3'd3,
    CMD_SCHED_OUT  = 3'd4,
    CMD_CHECK      = 3'd5,
    CMD_TIMER      = 3'd6,
    CMD_UNTHROTTLE = 3'd7
  } cmd_t;

  typedef enum logic [0:0] {
    REG_PERIOD_BUDGET = 1'b0,
    REG_THROTTLE_THRESHOLD = 1'b1
  } cfg_idx_t;

  // classified event, front to back
  typedef struct packed {
    logic [LANES-1:0]     clr_rt;     // zero the accumulated runtime
    logic [LANES-1:0]     set_start;  // restart the open interval at now
    logic                 accum;      // fold open intervals into runtimes
    logic                 check;      // run a budget check
    logic                 unthrottle;
    logic                 sleeping;
    logic [TIME_BITS-1:0] now;
  } op_t;

  // usages after the accounting stages
  typedef struct packed {
    logic                            valid;
    logic                            check;
    logic                            unthrottle;
    logic [LANES-1:0][TIME_BITS-1:0] usage;
  } use_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   job_usage1;
    logic [TIME_BITS-1:0]   job_usage2;
    logic [TIME_BITS-1:0]   period_usage;
    logic [BUDGET_BITS-1:0] remaining_budget;
    logic                   newly_throttled;
    logic                   throttled_flag;
    logic                   timer_armed;
    logic [BUDGET_BITS-1:0] timer_delay;
    logic [CNT_BITS-1:0]    overuse_events;
    logic [TIME_BITS-1:0]   max_overuse;
  } res_t;

  function automatic logic [BUDGET_BITS-1:0] sat40(input logic [TIME_BITS-1:0] v);
    logic over;
    over = |v[TIME_BITS-1:BUDGET_BITS];
    return over ? '1 : v[BUDGET_BITS-1:0];
  endfunction

endpackage

### src/rba_in_if.sv
// ----------------------------------------------------------------------------
// rba_in_if
// Event channel: valid/ready plus one scheduling event per word.
// ----------------------------------------------------------------------------
interface rba_in_if;
  logic                             valid;
  logic                             ready;
  logic [rba_pkg::CMD_BITS-1:0]     cmd;
  logic [rba_pkg::TIME_BITS-1:0]    now;
  logic                             asleep;
  logic                             allocator_running;

  modport source (output valid, cmd, now, asleep, allocator_running, input ready);
  modport sink   (input valid, cmd, now, asleep, allocator_running, output ready);
endinterface

### src/rba_out_if.sv
// ----------------------------------------------------------------------------
// rba_out_if
// Result channel: valid/ready plus usages and enforcement status per word.
// ----------------------------------------------------------------------------
interface rba_out_if;
  logic                             valid;
  logic                             ready;
  logic [rba_pkg::TIME_BITS-1:0]    job_usage1;
  logic [rba_pkg::TIME_BITS-1:0]    job_usage2;
  logic [rba_pkg::TIME_BITS-1:0]    period_usage;
  logic [rba_pkg::BUDGET_BITS-1:0]  remaining_budget;
  logic                             newly_throttled;
  logic                             throttled_flag;
  logic                             timer_armed;
  logic [rba_pkg::BUDGET_BITS-1:0]  timer_delay;
  logic [rba_pkg::CNT_BITS-1:0]     overuse_events;
  logic [rba_pkg::TIME_BITS-1:0]    max_overuse;

  modport source (output valid, job_usage1, job_usage2, period_usage, remaining_budget,
                  newly_throttled, throttled_flag, timer_armed, timer_delay,
                  overuse_events, max_overuse, input ready);
  modport sink   (input valid, job_usage1, job_usage2, period_usage, remaining_budget,
                  newly_throttled, throttled_flag, timer_armed, timer_delay,
                  overuse_events, max_overuse, output ready);
endinterface

### src/rba_front.sv
// ----------------------------------------------------------------------------
// rba_front
// Accepts event words and decodes the command into lane controls.
// ----------------------------------------------------------------------------
module rba_front (
  rba_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output rba_pkg::op_t  q_data
);
  import rba_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_data            = '0;
    q_data.now        = in_ch.now;
    q_data.sleeping   = in_ch.asleep;
    unique case (cmd_t'(in_ch.cmd))
      CMD_FIRST_JOB: begin
        q_data.clr_rt    = '1;
        q_data.set_start = '1;
      end
      CMD_BOUNDARY1: begin
        q_data.clr_rt[LANE_ONE]    = 1'b1;
        q_data.set_start[LANE_ONE] = 1'b1;
      end
      CMD_BOUNDARY2: begin
        q_data.clr_rt[LANE_TWO]    = 1'b1;
        q_data.set_start[LANE_TWO] = 1'b1;
      end
      CMD_SCHED_IN:   q_data.set_start  = '1;
      CMD_SCHED_OUT:  q_data.accum      = 1'b1;
      CMD_CHECK:      q_data.check      = 1'b1;
      CMD_TIMER:      q_data.check      = in_ch.allocator_running;
      CMD_UNTHROTTLE: q_data.unthrottle = 1'b1;
      default:        q_data.unthrottle = 1'b0;
    endcase
  end

endmodule

### src/rba_queue.sv
// ----------------------------------------------------------------------------
// rba_queue
// Short queue of decoded events between front and back.
// ----------------------------------------------------------------------------
module rba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rba_pkg::op_t  push_data,
  output logic          full,
  input  logic          pop,
  output rba_pkg::op_t  pop_data,
  output logic          empty
);
  import rba_pkg::*;

  op_t                  entry [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full     = count == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/rba_usage.sv
// ----------------------------------------------------------------------------
// rba_usage
// Runtime accounting: start/runtime registers of the three lanes and the
// two stages that produce the current usages.
// ----------------------------------------------------------------------------
module rba_usage #(
  parameter int TW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          q_empty,
  input  rba_pkg::op_t  q_data,
  output logic          q_pop,
  output rba_pkg::use_t use_out
);
  import rba_pkg::*;

  logic [TW-1:0] start   [LANES];
  logic [TW-1:0] runtime [LANES];

  logic [TW-1:0] now_t;
  logic [TW-1:0] delta      [LANES];
  logic [TW-1:0] rt_next    [LANES];
  logic [TW-1:0] start_next [LANES];
  logic [TW-1:0] open_next  [LANES];
  logic [TW-1:0] usage_sum  [LANES];

  // stage 1 registers
  logic          s1_valid;
  logic          s1_check;
  logic          s1_unthr;
  logic [TW-1:0] s1_acc  [LANES];
  logic [TW-1:0] s1_open [LANES];

  assign q_pop = advance && !q_empty;
  assign now_t = q_data.now[TW-1:0];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      delta[i]      = now_t - start[i];
      rt_next[i]    = q_data.clr_rt[i] ? '0 :
                      q_data.accum     ? runtime[i] + delta[i] : runtime[i];
      start_next[i] = q_data.set_start[i] ? now_t : start[i];
      // a restarted interval is empty
      open_next[i]  = (q_data.sleeping || q_data.set_start[i]) ? '0 : delta[i];
      // wraps at the time width before widening to the port
      usage_sum[i]  = s1_acc[i] + s1_open[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        start[i]   <= '0;
        runtime[i] <= '0;
      end
    end else if (q_pop) begin
      for (int i = 0; i < LANES; i++) begin
        start[i]   <= start_next[i];
        runtime[i] <= rt_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      use_out.valid <= 1'b0;
    end else if (advance) begin
      s1_valid           <= !q_empty;
      use_out.valid      <= s1_valid;
      s1_check           <= q_data.check;
      s1_unthr           <= q_data.unthrottle;
      use_out.check      <= s1_check;
      use_out.unthrottle <= s1_unthr;
      for (int i = 0; i < LANES; i++) begin
        s1_acc[i]        <= rt_next[i];
        s1_open[i]       <= open_next[i];
        use_out.usage[i] <= TIME_BITS'(usage_sum[i]);
      end
    end
  end

endmodule

### src/rba_enforce.sv
// ----------------------------------------------------------------------------
// rba_enforce
// Budget check, throttle flag, overuse statistics and the output register.
// ----------------------------------------------------------------------------
module rba_enforce #(
  parameter int TW = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rba_pkg::use_t                    use_in,
  input  logic [rba_pkg::BUDGET_BITS-1:0]  budget,
  input  logic [rba_pkg::THRESH_BITS-1:0]  thresh,
  input  logic                             out_ready,
  output logic                             advance,
  output logic                             out_valid,
  output rba_pkg::res_t                    res
);
  import rba_pkg::*;

  logic [TIME_BITS-1:0] ext_use;
  logic [TIME_BITS-1:0] budget_x;

  // stage 3 registers
  logic                            s3_valid;
  logic                            s3_check;
  logic                            s3_unthr;
  logic [LANES-1:0][TIME_BITS-1:0] s3_usage;
  logic [TIME_BITS-1:0]            s3_rem;
  logic [TIME_BITS-1:0]            s3_over;

  // enforcement state
  logic                 thr_state;
  logic [CNT_BITS-1:0]  ovr_cnt;
  logic [TIME_BITS-1:0] ovr_peak;

  logic                 neg;
  logic                 below;
  logic                 hit;
  logic                 thr_next;
  logic [CNT_BITS-1:0]  cnt_next;
  logic [TIME_BITS-1:0] peak_next;
  logic                 armed;
  logic [TIME_BITS-1:0] delay_raw;

  assign advance = !out_valid || out_ready;

  always_comb begin
    ext_use = {TIME_BITS{use_in.usage[LANE_PER][TW-1]}};
    ext_use[TW-1:0] = use_in.usage[LANE_PER][TW-1:0];
    budget_x = TIME_BITS'(budget);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_check <= use_in.check;
      s3_unthr <= use_in.unthrottle;
      s3_usage <= use_in.usage;
      s3_rem   <= budget_x - ext_use;
      s3_over  <= ext_use - budget_x;
    end
  end

  always_comb begin
    neg       = s3_rem[TIME_BITS-1];
    below     = neg || (s3_rem < TIME_BITS'(thresh));
    hit       = s3_check && below;
    thr_next  = s3_unthr ? 1'b0 : (hit ? 1'b1 : thr_state);
    cnt_next  = ovr_cnt;
    peak_next = ovr_peak;
    if (s3_check && neg) begin
      if (s3_over > TIME_BITS'(thresh) && ovr_cnt != '1) begin
        cnt_next = ovr_cnt + 1'b1;
      end
      if (s3_over > ovr_peak) begin
        peak_next = s3_over;
      end
    end
    armed     = s3_check && !below && (s3_rem != '0);
    delay_raw = s3_rem - TIME_BITS'(thresh[THRESH_BITS-1:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      thr_state <= 1'b0;
      ovr_cnt   <= '0;
      ovr_peak  <= '0;
    end else if (advance) begin
      s3_valid  <= use_in.valid;
      out_valid <= s3_valid;
      if (s3_valid) begin
        thr_state <= thr_next;
        ovr_cnt   <= cnt_next;
        ovr_peak  <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.job_usage1       <= s3_usage[LANE_ONE];
      res.job_usage2       <= s3_usage[LANE_TWO];
      res.period_usage     <= s3_usage[LANE_PER];
      res.remaining_budget <= (s3_check && !below) ? sat40(s3_rem) : '0;
      res.newly_throttled  <= hit && !thr_state;
      res.throttled_flag   <= thr_next;
      res.timer_armed      <= armed;
      res.timer_delay      <= armed ? sat40(delay_raw) : '0;
      res.overuse_events   <= cnt_next;
      res.max_overuse      <= peak_next;
    end
  end

endmodule

### src/reservation_budget_accounting_top.sv
// ----------------------------------------------------------------------------
// reservation_budget_accounting_top
// CPU reservation budget accounting with throttle enforcement.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one scheduling event per word (cmd, now, asleep,
//   allocator_running); out_ch returns one result word per event, in order,
//   with the three usages and the check outcome.
//   Configuration: cfg_we/cfg_idx/cfg_data write period_budget (index 0) or
//   throttle_threshold (index 1); write only while idle.
//   Path: a word accepted on in_ch passes the queue, two accounting stages,
//   the check stage and the output register before it shows on out_ch.
//   Throughput: one word per cycle while out_ch is not stalled; the runtime
//   and throttle registers each close their loop within a single stage.
//   Receiver stall: the back stages and output register hold; the two-entry
//   queue keeps taking words until it is full, then in_ch.ready drops.
//   Reset (rst, synchronous): all runtimes, start times, throttle flag and
//   overuse statistics clear; the threshold returns to 5000 ns, the budget
//   to 0. No clearing pass: the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module reservation_budget_accounting_top #(
  parameter int TIME_WIDTH = 64  // time arithmetic wraps at 2^TIME_WIDTH (32..64)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_idx,
  input  logic [rba_pkg::CFG_BITS-1:0]    cfg_data,
  rba_in_if.sink                          in_ch,
  rba_out_if.source                       out_ch
);
  import rba_pkg::*;

  // config registers
  logic [BUDGET_BITS-1:0] period_budget;
  logic [THRESH_BITS-1:0] throttle_threshold;

  // front -> queue
  logic q_push;
  logic q_full;
  op_t  q_wdata;
  // queue -> back
  logic q_pop;
  logic q_empty;
  op_t  q_rdata;

  use_t use_w;
  logic advance;
  logic out_valid;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_budget      <= '0;
      throttle_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_PERIOD_BUDGET:      period_budget      <= cfg_data[BUDGET_BITS-1:0];
        REG_THROTTLE_THRESHOLD: throttle_threshold <= cfg_data[THRESH_BITS-1:0];
        default:                period_budget      <= period_budget;
      endcase
    end
  end

  // front: accept and decode
  rba_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // decouples acceptance from back-end stalls
  rba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back, part one: runtime accounting
  rba_usage #(.TW(TIME_WIDTH)) u_usage (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .use_out (use_w)
  );

  // back, part two: budget check and output register
  rba_enforce #(.TW(TIME_WIDTH)) u_enforce (
    .clk       (clk),
    .rst       (rst),
    .use_in    (use_w),
    .budget    (period_budget),
    .thresh    (throttle_threshold),
    .out_ready (out_ch.ready),
    .advance   (advance),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.job_usage1       = res.job_usage1;
  assign out_ch.job_usage2       = res.job_usage2;
  assign out_ch.period_usage     = res.period_usage;
  assign out_ch.remaining_budget = res.remaining_budget;
  assign out_ch.newly_throttled  = res.newly_throttled;
  assign out_ch.throttled_flag   = res.throttled_flag;
  assign out_ch.timer_armed      = res.timer_armed;
  assign out_ch.timer_delay      = res.timer_delay;
  assign out_ch.overuse_events   = res.overuse_events;
  assign out_ch.max_overuse      = res.max_overuse;

`ifndef SYNTHESIS
  // an armed timer means the check left budget and did not throttle
  a_armed_consistent: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.timer_armed |->
      out_ch.remaining_budget != '0 && !out_ch.newly_throttled)
    else $error("timer armed with no budget left");

  // the back end never reads an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a stalled result freezes the back end
  a_stall_holds_back: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !q_pop)
    else $error("back end moved during output stall");
`endif

endmodule
